[design/pidl_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the positional list.
package pidl_pkg;

    localparam int DEPTH = 32;
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_ELEM   = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic              do_ins;
        logic              do_del;
        logic              ld_res;
        logic              ld_elem;
        logic [ST_W-1:0]   res_status;
        logic              res_last;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
    } t_dp_cmd;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              full;
        logic              empty;
    } t_dp_stat;

endpackage

[design/pidl_datapath.sv]
// List cells, length counter and output payload registers.
module pidl_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pidl_pkg::t_dp_cmd             i_cmd,
    output pidl_pkg::t_dp_stat            o_stat,
    output logic [pidl_pkg::ST_W-1:0]     o_status,
    output logic [pidl_pkg::VAL_W-1:0]    o_element,
    output logic                          o_last
);

    logic [pidl_pkg::VAL_W-1:0] r_entries [pidl_pkg::DEPTH];
    logic [pidl_pkg::LEN_W-1:0] r_len;
    logic [pidl_pkg::ST_W-1:0]  r_status;
    logic [pidl_pkg::VAL_W-1:0] r_element;
    logic                       r_last;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < pidl_pkg::DEPTH; i++) begin
            if (i_cmd.do_ins) begin
                if (pidl_pkg::IDX_W'(i) == i_cmd.pos) begin
                    r_entries[i] <= i_cmd.value;
                end else if (i > 0 && pidl_pkg::IDX_W'(i) > i_cmd.pos) begin
                    r_entries[i] <= r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.do_del) begin
                if (i < pidl_pkg::DEPTH - 1 && pidl_pkg::IDX_W'(i) >= i_cmd.pos) begin
                    r_entries[i] <= r_entries[(i < pidl_pkg::DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.do_ins) begin
            r_len <= r_len + pidl_pkg::LEN_W'(1);
        end else if (i_cmd.do_del) begin
            r_len <= r_len - pidl_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_elem) begin
            r_status  <= pidl_pkg::ST_ELEM;
            r_element <= r_entries[i_cmd.idx];
            r_last    <= i_cmd.res_last;
        end else if (i_cmd.ld_res) begin
            r_status  <= i_cmd.res_status;
            r_element <= '0;
            r_last    <= 1'b1;
        end
    end

    assign o_stat.len   = r_len;
    assign o_stat.full  = (r_len == pidl_pkg::LEN_W'(pidl_pkg::DEPTH));
    assign o_stat.empty = (r_len == '0);
    assign o_status     = r_status;
    assign o_element    = r_element;
    assign o_last       = r_last;

endmodule

[design/pidl_controller.sv]
// Command decode, dump sequencer and output valid control.
module pidl_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pidl_pkg::CMD_W-1:0]    i_command,
    input  logic [pidl_pkg::POS_W-1:0]    i_position,
    input  logic [pidl_pkg::VAL_W-1:0]    i_value,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  pidl_pkg::t_dp_stat            i_stat,
    output pidl_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_valid, n_valid;
    logic [pidl_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                       out_free;
    logic                       take;
    logic                       idx_last;
    logic [pidl_pkg::CMP_W-1:0] pos_x;
    logic [pidl_pkg::CMP_W-1:0] len_x;

    assign out_free   = !r_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign take       = i_s_tvalid && o_s_tready;
    assign pos_x      = pidl_pkg::CMP_W'(i_position);
    assign len_x      = pidl_pkg::CMP_W'(i_stat.len);
    assign idx_last   = (pidl_pkg::LEN_W'(r_idx) + pidl_pkg::LEN_W'(1) == i_stat.len);

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_cmd            = '0;
        o_cmd.pos        = i_position[pidl_pkg::IDX_W-1:0];
        o_cmd.value      = i_value;
        o_cmd.idx        = r_idx;
        o_cmd.res_status = pidl_pkg::ST_REJECT;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.ld_res = 1'b1;
                    case (i_command)
                        pidl_pkg::CMD_INSERT: begin
                            if (!i_stat.full && pos_x <= len_x) begin
                                o_cmd.do_ins     = 1'b1;
                                o_cmd.res_status = pidl_pkg::ST_DONE;
                            end
                        end
                        pidl_pkg::CMD_DELETE: begin
                            if (pos_x < len_x) begin
                                o_cmd.do_del     = 1'b1;
                                o_cmd.res_status = pidl_pkg::ST_DONE;
                            end
                        end
                        pidl_pkg::CMD_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.res_status = pidl_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.ld_res = 1'b0;
                                n_state      = S_DUMP;
                                n_idx        = '0;
                            end
                        end
                        default: begin
                            o_cmd.res_status = pidl_pkg::ST_REJECT;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    o_cmd.ld_elem  = 1'b1;
                    o_cmd.res_last = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + pidl_pkg::IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.ld_res || o_cmd.ld_elem) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_m_tvalid = r_valid;

`ifndef SYNTHESIS
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_command != pidl_pkg::CMD_DUMP) |=> r_valid)
        else $error("accepted command produced no result");

    a_dump_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(i_stat.len))
        else $error("list length changed during dump");

    a_dump_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (pidl_pkg::LEN_W'(r_idx) < i_stat.len))
        else $error("dump index beyond list length");

    a_no_shift_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.do_ins || o_cmd.do_del) |-> (r_state == S_IDLE && !o_cmd.ld_elem))
        else $error("list shifted outside idle");
`endif

endmodule

[design/positional_insert_delete_list.sv]
// Top level of the positional insert/delete list.
//
// Input stream: one transfer per command. tuser holds the command
// (insert, delete, dump); tdata holds the position and the value.
// Output stream: status in tuser, element in tdata, tlast marks the final
// result of a command.
// Insert and delete shift the cells from the position on in the cycle
// the command is taken; their single result reaches the output next cycle.
// A dump of a list of N entries yields N transfers, one per cycle when the
// receiver keeps tready high, the first after the dump state is entered;
// the input is not ready until the last element is loaded into the output
// register. A dump of an empty list yields one empty-status transfer.
// One output register parts the two sides: a new command is taken in the
// same cycle the pending result is taken. When the receiver stalls, the
// result holds and the input stays not ready.
// Reset clears the list length and the output valid; cell contents are
// not cleared and never read before written.
module positional_insert_delete_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  logic [pidl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] command
    input  logic [pidl_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] element
    output logic [pidl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [pidl_pkg::ST_W-1:0]         m_axis_tuser,
    output logic                              m_axis_tlast
);

    pidl_pkg::t_dp_cmd           dp_cmd;
    pidl_pkg::t_dp_stat          dp_stat;
    logic [pidl_pkg::VAL_W-1:0]  element;

    pidl_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_command  (s_axis_tuser),
        .i_position (s_axis_tdata[pidl_pkg::POS_W-1:0]),
        .i_value    (s_axis_tdata[pidl_pkg::POS_W +: pidl_pkg::VAL_W]),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    pidl_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .o_status  (m_axis_tuser),
        .o_element (element),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = pidl_pkg::M_TDATA_W'(element);

endmodule
